// ===== hdl/spring_bungee_force_assert.svh =====
`ifndef SPRING_BUNGEE_FORCE_ASSERT_SVH
`define SPRING_BUNGEE_FORCE_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define SBF_ASSERT_NOW(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("spring_bungee_force: same-cycle check failed");

// Check a condition in the cycle after its trigger.
`define SBF_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("spring_bungee_force: next-cycle check failed");

`endif

// ===== hdl/sbf_pkg.sv =====
`timescale 1ns / 1ps

package sbf_pkg;

    localparam int DEF_FRAC_BITS   = 16;
    localparam int DEF_COORD_WIDTH = 32;

    // Register width of the configuration port
    localparam int REG_WIDTH = 32;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPRING_CONSTANT = 2'd0,
        CFG_REST_LENGTH     = 2'd1,
        CFG_BUNGEE_MODE     = 2'd2
    } cfg_index_t;

    localparam logic [REG_WIDTH-1:0] RESET_SPRING_CONSTANT = 32'd65536;
    localparam logic [REG_WIDTH-1:0] RESET_REST_LENGTH     = 32'd65536;
    localparam logic                 RESET_BUNGEE_MODE     = 1'b0;

    // Per-request control carried through the divide stages
    typedef struct packed {
        logic [2:0] neg;
        logic [2:0] nz;
        logic       kill;
        logic       applied;
    } sbf_ctl_t;

endpackage

// ===== hdl/sbf_if.sv =====
`timescale 1ns / 1ps

interface sbf_item_if #(
    parameter int COORD_WIDTH = sbf_pkg::DEF_COORD_WIDTH
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;
    logic signed [COORD_WIDTH-1:0] end_z;

    modport source (output valid, pos_x, pos_y, pos_z, end_x, end_y, end_z, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, end_x, end_y, end_z, output ready);
endinterface

interface sbf_result_if #(
    parameter int COORD_WIDTH = sbf_pkg::DEF_COORD_WIDTH
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] force_x;
    logic signed [COORD_WIDTH-1:0] force_y;
    logic signed [COORD_WIDTH-1:0] force_z;
    logic                          force_applied;

    modport source (output valid, force_x, force_y, force_z, force_applied, input ready);
    modport sink   (input valid, force_x, force_y, force_z, force_applied, output ready);
endinterface

// ===== hdl/spring_bungee_force.sv =====
`timescale 1ns / 1ps

// Spring / bungee force on one particle: each request carries a particle position and
// the far end position (signed fixed point, FRAC_BITS fraction bits); the block returns
// force = -k*|L - rest|*d/L per axis, truncated toward zero and saturated, with
// force_applied low for a slack bungee (bungee mode and L <= rest, forces zero). A zero
// length in spring mode gives zero force. The pipeline takes one request per clock while
// the result side does not stall and holds no state between requests; most of its stages
// are the bit-per-stage square root (COORD_WIDTH + 2 stages) and the bit-per-stage
// restoring divider (COORD_WIDTH + 1 stages). A stall on the result side freezes the
// whole pipeline. Write configuration only while no request is in flight.
module spring_bungee_force #(
    parameter int FRAC_BITS   = sbf_pkg::DEF_FRAC_BITS,
    parameter int COORD_WIDTH = sbf_pkg::DEF_COORD_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [sbf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sbf_pkg::REG_WIDTH-1:0] cfg_data,
    sbf_item_if.sink                      item,
    sbf_result_if.source                  result
);
    import sbf_pkg::*;

    localparam int DW    = COORD_WIDTH + 1;
    localparam int SUMW  = 2 * DW + 2;
    localparam int LW    = DW + 1;
    localparam int STW   = (LW > REG_WIDTH) ? LW : REG_WIDTH;
    localparam int SCW   = REG_WIDTH + STW;
    localparam int LOW   = REG_WIDTH + DW;
    localparam int HIW   = STW + DW;
    localparam int NUMW  = SCW + DW;
    localparam int DENW  = LW + FRAC_BITS;
    localparam int DSW   = DENW + COORD_WIDTH + 1;
    localparam int CMPW  = (NUMW > DSW) ? NUMW : DSW;
    localparam int QW    = COORD_WIDTH;
    localparam int DVN   = QW + 1;

    localparam logic [QW-1:0] MAX_POS = {1'b0, {(QW-1){1'b1}}};
    localparam logic [QW-1:0] MIN_NEG = {1'b1, {(QW-1){1'b0}}};

    logic adv;
    logic out_valid_reg;

    // Advance the whole pipeline whenever the output register is free
    assign adv        = !out_valid_reg || result.ready;
    assign item.ready = adv;

    // Configuration registers
    logic [REG_WIDTH-1:0] k_reg;
    logic [REG_WIDTH-1:0] rest_reg;
    logic                 bungee_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg      <= RESET_SPRING_CONSTANT;
            rest_reg   <= RESET_REST_LENGTH;
            bungee_reg <= RESET_BUNGEE_MODE;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_SPRING_CONSTANT: k_reg      <= cfg_data;
                CFG_REST_LENGTH:     rest_reg   <= cfg_data;
                CFG_BUNGEE_MODE:     bungee_reg <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    // Stage A: difference, magnitude and sign per axis
    logic [2:0][COORD_WIDTH-1:0] pos_in, end_in;
    logic [2:0][DW-1:0]          a_d;
    logic [2:0][DW-1:0]          a_ad_reg;
    logic [2:0]                  a_neg_reg, a_nz_reg;
    logic                        a_valid_reg;

    assign pos_in = {item.pos_z, item.pos_y, item.pos_x};
    assign end_in = {item.end_z, item.end_y, item.end_x};

    always_comb
    begin
        for (int ax = 0; ax < 3; ax++)
        begin
            a_d[ax] = {pos_in[ax][COORD_WIDTH-1], pos_in[ax]}
                    - {end_in[ax][COORD_WIDTH-1], end_in[ax]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= item.valid;
            for (int ax = 0; ax < 3; ax++)
            begin
                a_ad_reg[ax]  <= a_d[ax][DW-1] ? (DW'(0) - a_d[ax]) : a_d[ax];
                a_neg_reg[ax] <= a_d[ax][DW-1];
                a_nz_reg[ax]  <= |a_d[ax];
            end
        end
    end

    // Stage B: squares
    logic [2:0][2*DW-1:0] b_sq_reg;
    logic [2:0][DW-1:0]   b_ad_reg;
    logic [2:0]           b_neg_reg, b_nz_reg;
    logic                 b_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg <= a_valid_reg;
            for (int ax = 0; ax < 3; ax++)
            begin
                b_sq_reg[ax] <= (2*DW)'(a_ad_reg[ax]) * (2*DW)'(a_ad_reg[ax]);
            end
            b_ad_reg  <= a_ad_reg;
            b_neg_reg <= a_neg_reg;
            b_nz_reg  <= a_nz_reg;
        end
    end

    // Stage C: sum of squares
    logic [SUMW-1:0]    c_sum_reg;
    logic [2:0][DW-1:0] c_ad_reg;
    logic [2:0]         c_neg_reg, c_nz_reg;
    logic               c_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            c_valid_reg <= b_valid_reg;
            c_sum_reg   <= SUMW'(b_sq_reg[0]) + SUMW'(b_sq_reg[1]) + SUMW'(b_sq_reg[2]);
            c_ad_reg    <= b_ad_reg;
            c_neg_reg   <= b_neg_reg;
            c_nz_reg    <= b_nz_reg;
        end
    end

    // Square root: one result bit per stage, most significant first
    logic [SUMW-1:0]    sq_rem_reg   [LW];
    logic [LW-1:0]      sq_root_reg  [LW];
    logic [2:0][DW-1:0] sq_ad_reg    [LW];
    logic [2:0]         sq_neg_reg   [LW];
    logic [2:0]         sq_nz_reg    [LW];
    logic               sq_valid_reg [LW];

    for (genvar s = 0; s < LW; s++)
    begin : g_sqrt
        localparam int B = LW - 1 - s;

        logic [SUMW-1:0]    rem_in;
        logic [SUMW-1:0]    trial;
        logic [LW-1:0]      root_in;
        logic [2:0][DW-1:0] ad_in;
        logic [2:0]         neg_in, nz_in;
        logic               vin;
        logic               take;

        if (s == 0)
        begin : g_first
            assign rem_in  = c_sum_reg;
            assign root_in = '0;
            assign ad_in   = c_ad_reg;
            assign neg_in  = c_neg_reg;
            assign nz_in   = c_nz_reg;
            assign vin     = c_valid_reg;
        end
        else
        begin : g_next
            assign rem_in  = sq_rem_reg[s-1];
            assign root_in = sq_root_reg[s-1];
            assign ad_in   = sq_ad_reg[s-1];
            assign neg_in  = sq_neg_reg[s-1];
            assign nz_in   = sq_nz_reg[s-1];
            assign vin     = sq_valid_reg[s-1];
        end

        // Growth of the square when this bit is set: root*2^(B+1) + 2^(2B)
        assign trial = (SUMW'(root_in) << (B + 1)) + (SUMW'(1) << (2 * B));
        assign take  = rem_in >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_valid_reg[s] <= 1'b0;
            end
            else if (adv)
            begin
                sq_valid_reg[s] <= vin;
                sq_rem_reg[s]   <= take ? (rem_in - trial) : rem_in;
                sq_root_reg[s]  <= root_in | (LW'(take) << B);
                sq_ad_reg[s]    <= ad_in;
                sq_neg_reg[s]   <= neg_in;
                sq_nz_reg[s]    <= nz_in;
            end
        end
    end

    // Stage D: slack and zero-length checks, stretch
    logic [LW-1:0]      len;
    logic [STW-1:0]     len_x, rest_x;
    logic [STW-1:0]     d_stretch_reg;
    logic [LW-1:0]      d_len_reg;
    logic [2:0][DW-1:0] d_ad_reg;
    sbf_ctl_t           d_ctl_reg;
    logic               d_valid_reg;
    logic               slack;

    assign len    = sq_root_reg[LW-1];
    assign len_x  = STW'(len);
    assign rest_x = STW'(rest_reg);
    assign slack  = bungee_reg && (len_x <= rest_x);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            d_valid_reg       <= sq_valid_reg[LW-1];
            d_stretch_reg     <= (len_x >= rest_x) ? (len_x - rest_x) : (rest_x - len_x);
            d_len_reg         <= len;
            d_ad_reg          <= sq_ad_reg[LW-1];
            d_ctl_reg.neg     <= sq_neg_reg[LW-1];
            d_ctl_reg.nz      <= sq_nz_reg[LW-1];
            d_ctl_reg.kill    <= slack || (len == '0);
            d_ctl_reg.applied <= !slack;
        end
    end

    // Stage E: scale = k * stretch
    logic [SCW-1:0]     e_scale_reg;
    logic [LW-1:0]      e_len_reg;
    logic [2:0][DW-1:0] e_ad_reg;
    sbf_ctl_t           e_ctl_reg;
    logic               e_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            e_valid_reg <= d_valid_reg;
            e_scale_reg <= SCW'(k_reg) * SCW'(d_stretch_reg);
            e_len_reg   <= d_len_reg;
            e_ad_reg    <= d_ad_reg;
            e_ctl_reg   <= d_ctl_reg;
        end
    end

    // Stage F: partial products of scale * |d| per axis
    logic [2:0][LOW-1:0] f_lo_reg;
    logic [2:0][HIW-1:0] f_hi_reg;
    logic [LW-1:0]       f_len_reg;
    sbf_ctl_t            f_ctl_reg;
    logic                f_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f_valid_reg <= e_valid_reg;
            for (int ax = 0; ax < 3; ax++)
            begin
                f_lo_reg[ax] <= LOW'(e_scale_reg[REG_WIDTH-1:0]) * LOW'(e_ad_reg[ax]);
                f_hi_reg[ax] <= HIW'(e_scale_reg[SCW-1:REG_WIDTH]) * HIW'(e_ad_reg[ax]);
            end
            f_len_reg <= e_len_reg;
            f_ctl_reg <= e_ctl_reg;
        end
    end

    // Stage G: combine partial products, form the divisor
    logic [2:0][CMPW-1:0] g_num_reg;
    logic [DENW-1:0]      g_den_reg;
    sbf_ctl_t             g_ctl_reg;
    logic                 g_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            g_valid_reg <= f_valid_reg;
            for (int ax = 0; ax < 3; ax++)
            begin
                g_num_reg[ax] <= CMPW'((NUMW'(f_hi_reg[ax]) << REG_WIDTH)
                                       + NUMW'(f_lo_reg[ax]));
            end
            g_den_reg <= DENW'(f_len_reg) << FRAC_BITS;
            g_ctl_reg <= f_ctl_reg;
        end
    end

    // Divide: first stage flags overflow, then one quotient bit per stage
    logic [2:0][CMPW-1:0] dv_rem_reg   [DVN];
    logic [2:0][QW-1:0]   dv_q_reg     [DVN];
    logic [2:0]           dv_ovf_reg   [DVN];
    logic [DENW-1:0]      dv_den_reg   [DVN];
    sbf_ctl_t             dv_ctl_reg   [DVN];
    logic                 dv_valid_reg [DVN];

    for (genvar t = 0; t < DVN; t++)
    begin : g_div
        localparam int SH = QW - t;

        logic [2:0][CMPW-1:0] rem_in, rem_nx;
        logic [2:0][QW-1:0]   q_in, q_nx;
        logic [2:0]           ovf_in, ovf_nx;
        logic [DENW-1:0]      den_in;
        sbf_ctl_t             ctl_in;
        logic                 vin;
        logic [CMPW-1:0]      dsh;
        logic [2:0]           take;

        if (t == 0)
        begin : g_first
            assign rem_in = g_num_reg;
            assign q_in   = '0;
            assign ovf_in = '0;
            assign den_in = g_den_reg;
            assign ctl_in = g_ctl_reg;
            assign vin    = g_valid_reg;
        end
        else
        begin : g_next
            assign rem_in = dv_rem_reg[t-1];
            assign q_in   = dv_q_reg[t-1];
            assign ovf_in = dv_ovf_reg[t-1];
            assign den_in = dv_den_reg[t-1];
            assign ctl_in = dv_ctl_reg[t-1];
            assign vin    = dv_valid_reg[t-1];
        end

        assign dsh = CMPW'(den_in) << SH;

        always_comb
        begin
            for (int ax = 0; ax < 3; ax++)
            begin
                take[ax]   = rem_in[ax] >= dsh;
                rem_nx[ax] = take[ax] ? (rem_in[ax] - dsh) : rem_in[ax];
                q_nx[ax]   = q_in[ax] | (QW'(take[ax]) << SH);
                ovf_nx[ax] = ovf_in[ax] | ((t == 0) && take[ax]);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[t] <= 1'b0;
            end
            else if (adv)
            begin
                dv_valid_reg[t] <= vin;
                dv_rem_reg[t]   <= rem_nx;
                dv_q_reg[t]     <= q_nx;
                dv_ovf_reg[t]   <= ovf_nx;
                dv_den_reg[t]   <= den_in;
                dv_ctl_reg[t]   <= ctl_in;
            end
        end
    end

    // Output stage: sign, saturate, drop killed axes
    logic [2:0][QW-1:0] force_nx;
    logic [2:0][QW-1:0] out_force_reg;
    logic               out_applied_reg;
    sbf_ctl_t           last_ctl;
    logic [2:0][QW-1:0] last_q;
    logic [2:0]         last_ovf;

    assign last_ctl = dv_ctl_reg[DVN-1];
    assign last_q   = dv_q_reg[DVN-1];
    assign last_ovf = dv_ovf_reg[DVN-1];

    always_comb
    begin
        for (int ax = 0; ax < 3; ax++)
        begin
            if (last_ctl.kill || !last_ctl.nz[ax])
            begin
                force_nx[ax] = '0;
            end
            else if (last_ctl.neg[ax])
            begin
                force_nx[ax] = (last_ovf[ax] || last_q[ax][QW-1]) ? MAX_POS : last_q[ax];
            end
            else
            begin
                force_nx[ax] = (last_ovf[ax] || (last_q[ax] > MIN_NEG)) ? MIN_NEG
                             : (QW'(0) - last_q[ax]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg   <= dv_valid_reg[DVN-1];
            out_force_reg   <= force_nx;
            out_applied_reg <= last_ctl.applied;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.force_x       = out_force_reg[0];
    assign result.force_y       = out_force_reg[1];
    assign result.force_z       = out_force_reg[2];
    assign result.force_applied = out_applied_reg;

endmodule

// ===== hdl/sbf_checker.sv =====
`timescale 1ns / 1ps
`include "spring_bungee_force_assert.svh"

module sbf_checker #(
    parameter int COORD_WIDTH = sbf_pkg::DEF_COORD_WIDTH
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   item_ready,
    input logic                   result_valid,
    input logic                   result_ready,
    input logic [COORD_WIDTH-1:0] force_x,
    input logic [COORD_WIDTH-1:0] force_y,
    input logic [COORD_WIDTH-1:0] force_z,
    input logic                   force_applied
);
    import sbf_pkg::*;

    logic [3*COORD_WIDTH:0] payload;
    logic                   force_zero;

    assign payload    = {force_x, force_y, force_z, force_applied};
    assign force_zero = (force_x == '0) && (force_y == '0) && (force_z == '0);

    // Hold a stalled result
    `SBF_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid)
    `SBF_ASSERT_NEXT(a_payload_held, result_valid && !result_ready, $stable(payload))

    // A slack bungee carries no force
    `SBF_ASSERT_NOW(a_slack_zero, result_valid && !force_applied, force_zero)

    // An empty output register never blocks a request
    `SBF_ASSERT_NOW(a_ready_when_empty, !result_valid, item_ready)

endmodule

bind spring_bungee_force sbf_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_sbf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_ready    (item.ready),
    .result_valid  (result.valid),
    .result_ready  (result.ready),
    .force_x       (result.force_x),
    .force_y       (result.force_y),
    .force_z       (result.force_z),
    .force_applied (result.force_applied)
);
